// File: rtl/lpv_pkg.sv
// Package for the LAN packet parser/validator: payload structs, phase codes,
// status codes, register indexes and the UTF-8 checker function. No dependencies.
package lpv_pkg;

  localparam logic [31:0] MAGIC_WORD   = 32'h4e4c485a;
  localparam logic [16:0] HEADER_BYTES = 17'd12;
  localparam logic [16:0] POS_MAX      = 17'h1FFFF;

  typedef enum logic [3:0] {
    PH_HDR, PH_WORDS, PH_TLEN0, PH_TLEN1, PH_TEXT, PH_CLEN0, PH_CLEN1,
    PH_SLEN0, PH_SLEN1, PH_CMD, PH_DONE, PH_ERR
  } phase_t;

  localparam logic [4:0] ST_OK = 5'd0, ST_LONG = 5'd1, ST_SHORT = 5'd2,
    ST_MAGIC = 5'd3, ST_VERSION = 5'd4, ST_TYPE = 5'd5, ST_LENGTH = 5'd6,
    ST_TEXT_LONG = 5'd7, ST_CMD_LONG = 5'd8, ST_PAST_END = 5'd9,
    ST_UTF8 = 5'd10, ST_TOO_MANY = 5'd11, ST_TRUNC = 5'd12,
    ST_TRAILING = 5'd13, ST_NO_CMDS = 5'd14, ST_CMDS_FORBID = 5'd15,
    ST_TEXT_FORBID = 5'd16;

  localparam logic [1:0] RK_TEXT = 2'd0, RK_CMD = 2'd1, RK_VERDICT = 2'd2;

  localparam logic [2:0] REG_VERSION = 3'd0, REG_TYPE_BASE = 3'd1,
    REG_DGRAM_LIMIT = 3'd2, REG_TEXT_LIMIT = 3'd3, REG_CMD_LIMIT = 3'd4,
    REG_COUNT_LIMIT = 3'd5;

  localparam logic [2:0] KIND_JOIN = 3'd1, KIND_ACCEPT = 3'd2, KIND_COMMAND = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  string_byte;
    logic [7:0]  command_slot;
    logic [4:0]  status;
    logic [2:0]  packet_kind;
    logic [31:0] sequence_word;
    logic [31:0] tick_word;
    logic [31:0] peer_word;
    logic [31:0] data_ident;
    logic [31:0] map_ident;
    logic [7:0]  commands_seen;
    logic        last_record;
  } out_item_t;

  // Result of one UTF-8 step: error flag and next pending code.
  typedef struct packed {
    logic       bad;
    logic [4:0] pending;
  } utf8_res_t;

  // pending[1:0]: continuation bytes due, pending[4:2]: range rule for the next one.
  function automatic utf8_res_t utf8_step(input logic [4:0] pend, input logic [7:0] b);
    utf8_res_t  r;
    logic [1:0] due;
    logic [2:0] rule;
    logic [7:0] lo;
    logic [7:0] hi;
    due  = pend[1:0];
    rule = pend[4:2];
    lo   = 8'h80;
    hi   = 8'hBF;
    r.bad     = 1'b0;
    r.pending = pend;
    if (due != 2'd0) begin
      case (rule)
        3'd1: lo = 8'hA0;
        3'd2: hi = 8'h9F;
        3'd3: lo = 8'h90;
        3'd4: hi = 8'h8F;
        default: ;
      endcase
      if (b < lo || b > hi) r.bad = 1'b1;
      else r.pending = {3'd0, due - 2'd1};
    end else if (b < 8'h80) begin
      r.pending = 5'd0;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      r.pending = 5'd1;
    end else if (b == 8'hE0) begin
      r.pending = {3'd1, 2'd2};
    end else if (b == 8'hED) begin
      r.pending = {3'd2, 2'd2};
    end else if (b >= 8'hE1 && b <= 8'hEF) begin
      r.pending = 5'd2;
    end else if (b == 8'hF0) begin
      r.pending = {3'd3, 2'd3};
    end else if (b == 8'hF4) begin
      r.pending = {3'd4, 2'd3};
    end else if (b >= 8'hF1 && b <= 8'hF3) begin
      r.pending = 5'd3;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: rtl/lpv_out_queue.sv
// Four-entry result queue that decouples the parser from the result channel.
// Depends on lpv_pkg for the result struct.
module lpv_out_queue
  import lpv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push0,
  input  out_item_t item0,
  input  logic      push1,
  input  out_item_t item1,
  output logic      room2,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  out_item_t  slot_r [4];
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r;
  logic       pop;
  logic [2:0] cnt_nxt;
  logic [1:0] n_push;

  assign pop       = out_valid && !out_stall;
  assign out_valid = cnt_r != 3'd0;
  assign out_item  = slot_r[rd_r];
  assign n_push    = {1'b0, push0} + {1'b0, push1};
  assign cnt_nxt   = cnt_r + {1'b0, n_push} - {2'b0, pop};
  // Room for a full two-result item, not counting a pop in this cycle.
  assign room2     = cnt_r <= 3'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 2'd0;
      wr_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
      wr_r  <= wr_r + n_push;
      if (pop) rd_r <= rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) slot_r[wr_r] <= item0;
    if (push1) slot_r[wr_r + {1'b0, push0}] <= item1;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push0 && push1) |-> cnt_r <= 3'd3)
    else $error("double push without room");
  a_push1_needs0: assert property (@(posedge clk) disable iff (!rst_n) push1 |-> push0)
    else $error("second push without first");
endmodule

// File: rtl/lan_packet_parse_validate.sv
// Top level of the LAN datagram parser/validator: APB registers, byte parser
// and result queue. Depends on lpv_pkg and lpv_out_queue.
//
// One datagram byte is taken per transfer and the block accepts a byte in
// every clock cycle while its four-entry result queue has room for two more
// results. Each byte is parsed by a single pass of logic from the parse state
// registers into the queue: text and command bytes leave as one result each,
// and the byte marked end_of_datagram adds a verdict with the decoded words
// and the first error, after which the parser returns to its header state.
// Results are registered in the result queue before they reach the output.
// Registers are to be written over the APB port only while no datagram is in progress; the block does not enforce this.
module lan_packet_parse_validate
  import lpv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers.
  logic [15:0] version_r, type_base_r, dgram_limit_r, text_limit_r, cmd_limit_r;
  logic [7:0]  count_limit_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r     <= 16'd1;
      type_base_r   <= 16'd0;
      dgram_limit_r <= 16'd1400;
      text_limit_r  <= 16'd256;
      cmd_limit_r   <= 16'd256;
      count_limit_r <= 8'd64;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_VERSION:     version_r     <= cfg_pwdata[15:0];
        REG_TYPE_BASE:   type_base_r   <= cfg_pwdata[15:0];
        REG_DGRAM_LIMIT: dgram_limit_r <= cfg_pwdata[15:0];
        REG_TEXT_LIMIT:  text_limit_r  <= cfg_pwdata[15:0];
        REG_CMD_LIMIT:   cmd_limit_r   <= cfg_pwdata[15:0];
        REG_COUNT_LIMIT: count_limit_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    unique case (reg_idx)
      REG_VERSION:     cfg_prdata = {16'd0, version_r};
      REG_TYPE_BASE:   cfg_prdata = {16'd0, type_base_r};
      REG_DGRAM_LIMIT: cfg_prdata = {16'd0, dgram_limit_r};
      REG_TEXT_LIMIT:  cfg_prdata = {16'd0, text_limit_r};
      REG_CMD_LIMIT:   cfg_prdata = {16'd0, cmd_limit_r};
      REG_COUNT_LIMIT: cfg_prdata = {24'd0, count_limit_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // Parse state.
  logic [16:0] pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] body_len_r, body_len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] cmd_total_r, cmd_total_nxt;
  logic [7:0]  cmd_cur_r, cmd_cur_nxt;
  logic [4:0]  utf_r, utf_nxt;
  logic        text_r, text_nxt;
  logic [4:0]  err_r, err_nxt;
  logic [31:0] words_r [5];
  logic [31:0] words_nxt [5];
  logic [2:0]  kind_r, kind_nxt;

  logic        room2, accept;
  logic        push0, push1;
  out_item_t   item0, item1, byte_item, verdict_item;
  logic [7:0]  b;
  logic        last;

  assign in_stall = !room2;
  assign accept   = in_valid && !in_stall;
  assign b        = in_data.data_byte;
  assign last     = in_data.end_of_datagram;

  // Per-byte decode helpers.
  logic [31:0] shift_merge;
  logic [15:0] count16, type_code, type_off;
  logic [17:0] used, rem_after;
  logic [16:0] body_off;
  logic [2:0]  word_idx;
  logic [1:0]  byte_idx;
  utf8_res_t   ur;
  logic        is_cmd, str_byte_out;
  logic [15:0] left_dec;
  logic [7:0]  cmd_inc;
  logic [4:0]  verdict_st;
  logic [16:0] size_after_hdr;

  assign byte_idx  = (phase_r == PH_HDR) ? pos_r[1:0] : body_off[1:0];
  assign body_off  = pos_r - HEADER_BYTES;
  assign word_idx  = body_off[4:2];
  assign shift_merge = ((byte_idx == 2'd0) ? 32'd0 : shift_r)
                       | ({24'd0, b} << {byte_idx, 3'b000});
  assign count16   = {b, shift_r[7:0]};
  assign type_code = shift_merge[31:16];
  assign type_off  = type_code - type_base_r;
  // Body bytes used through this one; compared as an 18-bit remainder.
  assign used      = {1'b0, pos_r} + 18'd1 - {1'b0, HEADER_BYTES};
  assign rem_after = (body_len_r >= {14'd0, used}) ? 18'(body_len_r - {14'd0, used})
                                                   : 18'd0;
  assign ur        = utf8_step(utf_r, b);
  assign is_cmd    = phase_r == PH_CMD;
  assign left_dec  = left_r - 16'd1;
  assign cmd_inc   = cmd_cur_r + 8'd1;

  // Count fits within remaining body (body_len may exceed 18 bits: rem_big then passes the check).
  logic rem_big;
  assign rem_big = body_len_r[31:18] != 14'd0 && body_len_r >= {14'd0, used};

  always_comb begin
    pos_nxt       = (pos_r < POS_MAX) ? pos_r + 17'd1 : POS_MAX;
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    body_len_nxt  = body_len_r;
    left_nxt      = left_r;
    cmd_total_nxt = cmd_total_r;
    cmd_cur_nxt   = cmd_cur_r;
    utf_nxt       = utf_r;
    text_nxt      = text_r;
    err_nxt       = err_r;
    kind_nxt      = kind_r;
    for (int i = 0; i < 5; i++) words_nxt[i] = words_r[i];
    str_byte_out  = 1'b0;
    unique case (phase_r)
      PH_HDR: begin
        shift_nxt = shift_merge;
        if (pos_r == 17'd3) begin
          if (shift_merge != MAGIC_WORD) begin err_nxt = ST_MAGIC; phase_nxt = PH_ERR; end
        end else if (pos_r == 17'd5) begin
          if (shift_merge[15:0] != version_r) begin
            err_nxt = ST_VERSION; phase_nxt = PH_ERR;
          end
        end else if (pos_r == 17'd7) begin
          if (type_code < type_base_r || type_off > 16'd5) begin
            err_nxt = ST_TYPE; phase_nxt = PH_ERR;
          end else begin
            kind_nxt = type_off[2:0];
          end
        end else if (pos_r >= 17'd11) begin
          body_len_nxt = shift_merge;
          phase_nxt    = PH_WORDS;
        end
      end
      PH_WORDS: begin
        shift_nxt = shift_merge;
        if (byte_idx == 2'd3 && word_idx < 3'd5) begin
          words_nxt[word_idx] = shift_merge;
          if (word_idx == 3'd4) phase_nxt = PH_TLEN0;
        end
      end
      PH_TLEN0, PH_CLEN0, PH_SLEN0: begin
        shift_nxt = {24'd0, b};
        phase_nxt = phase_t'(phase_r + 4'd1);
      end
      PH_TLEN1: begin
        if (count16 > text_limit_r) begin
          err_nxt = ST_TEXT_LONG; phase_nxt = PH_ERR;
        end else if (!rem_big && {2'd0, count16} > rem_after) begin
          err_nxt = ST_PAST_END; phase_nxt = PH_ERR;
        end else begin
          left_nxt  = count16;
          text_nxt  = count16 != 16'd0;
          utf_nxt   = 5'd0;
          phase_nxt = (count16 != 16'd0) ? PH_TEXT : PH_CLEN0;
        end
      end
      PH_CLEN1: begin
        cmd_total_nxt = count16;
        if (count16 > {8'd0, count_limit_r}) begin
          err_nxt = ST_TOO_MANY; phase_nxt = PH_ERR;
        end else begin
          cmd_cur_nxt = 8'd0;
          phase_nxt   = (count16 != 16'd0) ? PH_SLEN0 : PH_DONE;
        end
      end
      PH_SLEN1: begin
        if (count16 > cmd_limit_r) begin
          err_nxt = ST_CMD_LONG; phase_nxt = PH_ERR;
        end else if (!rem_big && {2'd0, count16} > rem_after) begin
          err_nxt = ST_PAST_END; phase_nxt = PH_ERR;
        end else begin
          left_nxt = count16;
          utf_nxt  = 5'd0;
          if (count16 != 16'd0) begin
            phase_nxt = PH_CMD;
          end else begin
            cmd_cur_nxt = cmd_inc;
            phase_nxt   = ({8'd0, cmd_inc} >= cmd_total_r) ? PH_DONE : PH_SLEN0;
          end
        end
      end
      PH_TEXT, PH_CMD: begin
        str_byte_out = 1'b1;
        if (ur.bad) begin
          err_nxt = ST_UTF8; phase_nxt = PH_ERR;
        end else begin
          utf_nxt  = ur.pending;
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            if (ur.pending[1:0] != 2'd0) begin
              err_nxt = ST_UTF8; phase_nxt = PH_ERR;
            end else begin
              utf_nxt = 5'd0;
              if (is_cmd) begin
                cmd_cur_nxt = cmd_inc;
                phase_nxt   = ({8'd0, cmd_inc} >= cmd_total_r) ? PH_DONE : PH_SLEN0;
              end else begin
                phase_nxt = PH_CLEN0;
              end
            end
          end
        end
      end
      PH_DONE: begin
        err_nxt = ST_TRAILING; phase_nxt = PH_ERR;
      end
      PH_ERR: ;
      default: ;
    endcase
  end

  // Verdict, computed from the state after this byte.
  assign size_after_hdr = pos_nxt - HEADER_BYTES;
  always_comb begin
    if (pos_nxt > {1'b0, dgram_limit_r})                 verdict_st = ST_LONG;
    else if (pos_nxt < HEADER_BYTES)                     verdict_st = ST_SHORT;
    else if (err_nxt >= ST_MAGIC && err_nxt <= ST_TYPE)  verdict_st = err_nxt;
    else if (body_len_nxt != {15'd0, size_after_hdr})    verdict_st = ST_LENGTH;
    else if (err_nxt != ST_OK)                           verdict_st = err_nxt;
    else if (phase_nxt != PH_DONE)                       verdict_st = ST_TRUNC;
    else if (kind_nxt == KIND_COMMAND && cmd_total_nxt == 16'd0) verdict_st = ST_NO_CMDS;
    else if (kind_nxt != KIND_COMMAND && cmd_total_nxt != 16'd0)
      verdict_st = ST_CMDS_FORBID;
    else if ((kind_nxt == KIND_JOIN || kind_nxt == KIND_ACCEPT || kind_nxt == KIND_COMMAND)
             && text_nxt)                                verdict_st = ST_TEXT_FORBID;
    else                                                 verdict_st = ST_OK;
  end

  always_comb begin
    byte_item              = '0;
    byte_item.record_kind  = is_cmd ? RK_CMD : RK_TEXT;
    byte_item.string_byte  = b;
    byte_item.command_slot = is_cmd ? cmd_cur_r : 8'd0;
    verdict_item               = '0;
    verdict_item.record_kind   = RK_VERDICT;
    verdict_item.status        = verdict_st;
    verdict_item.packet_kind   = kind_nxt;
    verdict_item.sequence_word = words_nxt[0];
    verdict_item.tick_word     = words_nxt[1];
    verdict_item.peer_word     = words_nxt[2];
    verdict_item.data_ident    = words_nxt[3];
    verdict_item.map_ident     = words_nxt[4];
    verdict_item.commands_seen = cmd_total_nxt[7:0];
    verdict_item.last_record   = 1'b1;
    if (str_byte_out) begin
      item0 = byte_item;
      item1 = verdict_item;
      push0 = accept;
      push1 = accept && last;
    end else begin
      item0 = verdict_item;
      item1 = verdict_item;
      push0 = accept && last;
      push1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last)) begin
      pos_r       <= '0;
      phase_r     <= PH_HDR;
      shift_r     <= '0;
      body_len_r  <= '0;
      left_r      <= '0;
      cmd_total_r <= '0;
      cmd_cur_r   <= '0;
      utf_r       <= '0;
      text_r      <= 1'b0;
      err_r       <= ST_OK;
      kind_r      <= '0;
      for (int i = 0; i < 5; i++) words_r[i] <= '0;
    end else if (accept) begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      body_len_r  <= body_len_nxt;
      left_r      <= left_nxt;
      cmd_total_r <= cmd_total_nxt;
      cmd_cur_r   <= cmd_cur_nxt;
      utf_r       <= utf_nxt;
      text_r      <= text_nxt;
      err_r       <= err_nxt;
      kind_r      <= kind_nxt;
      for (int i = 0; i < 5; i++) words_r[i] <= words_nxt[i];
    end
  end

  lpv_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .item0     (item0),
    .push1     (push1),
    .item1     (item1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_data)
  );

  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK) |-> phase_r == PH_ERR)
    else $error("error recorded without error phase");
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (pos_r == 17'd0 && phase_r == PH_HDR))
    else $error("parser not cleared after datagram end");
  a_cmd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CMD) |-> ({8'd0, cmd_cur_r} < cmd_total_r))
    else $error("command index beyond count");
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TEXT || phase_r == PH_CMD) |-> left_r != 16'd0)
    else $error("string phase with no bytes left");
endmodule
